FILE: src/prl_pkg.sv
// shared types, constants and helpers for the per-source connection rate limiter
// no dependencies
package prl_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

   localparam logic [1:0] REG_MAX_PER_MINUTE = 2'd0;
   localparam logic [1:0] REG_SWEEP_INTERVAL = 2'd1;
   localparam logic [1:0] REG_IDLE_LIMIT = 2'd2;

   localparam logic [15:0] RST_MAX_PER_MINUTE = 16'd0;
   localparam logic [5:0] RST_SWEEP_INTERVAL = 6'd10;
   localparam logic [5:0] RST_IDLE_LIMIT = 6'd3;

   typedef struct packed {
      logic [15:0] max_per_minute;
      logic [5:0] sweep_interval;
      logic [5:0] idle_limit;
   } cfg_type;

   typedef struct packed {
      logic [31:0] address;
      logic [5:0] minute;
      logic sweep;
      logic [23:0] prev_total;
   } job_type;

   typedef struct packed {
      logic allowed;
      logic table_full;
      logic [6:0] tracked_sources;
      logic [23:0] previous_minute_total;
   } result_type;

   typedef struct packed {
      logic [31:0] address;
      logic [5:0] minute;
      logic [15:0] count;
   } slot_type;

   // (later - earlier) modulo 60, both in 0..59
   function automatic logic [5:0] minute_gap(input logic [5:0] later,
                                             input logic [5:0] earlier);
      if (later >= earlier) begin
         minute_gap = later - earlier;
      end else begin
         minute_gap = later + MINUTES_PER_HOUR - earlier;
      end
   endfunction

endpackage

FILE: src/prl_csr.sv
// configuration registers behind an apb-style port
// depends on prl_pkg
module prl_csr (
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [3:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready,
   output prl_pkg::cfg_type cfg
);
   import prl_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic wr_en;

   assign wr_en = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_MAX_PER_MINUTE: cfg_in.max_per_minute = pwdata[15:0];
            REG_SWEEP_INTERVAL: cfg_in.sweep_interval = pwdata[5:0];
            REG_IDLE_LIMIT: cfg_in.idle_limit = pwdata[5:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_MAX_PER_MINUTE: prdata = {16'd0, cfg_ff.max_per_minute};
         REG_SWEEP_INTERVAL: prdata = {26'd0, cfg_ff.sweep_interval};
         REG_IDLE_LIMIT: prdata = {26'd0, cfg_ff.idle_limit};
         default: prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_per_minute <= RST_MAX_PER_MINUTE;
         cfg_ff.sweep_interval <= RST_SWEEP_INTERVAL;
         cfg_ff.idle_limit <= RST_IDLE_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: src/prl_front.sv
// front end: takes requests, keeps global minute totals and the sweep timer
// depends on prl_pkg
module prl_front (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  logic [31:0] source_address,
   input  logic [5:0] now_minute,
   input  logic q_full,
   input  prl_pkg::cfg_type cfg,
   output logic q_push,
   output prl_pkg::job_type q_job
);
   import prl_pkg::*;

   logic [5:0] total_minute_ff, total_minute_in;
   logic [23:0] current_total_ff, current_total_in;
   logic [23:0] previous_total_ff, previous_total_in;
   logic [5:0] sweep_start_ff, sweep_start_in;
   logic [5:0] now_n;
   logic sweep_due;

   assign q_push = push & ~q_full;
   assign now_n = (now_minute >= MINUTES_PER_HOUR) ? now_minute - MINUTES_PER_HOUR
                                                   : now_minute;
   assign sweep_due = minute_gap(now_n, sweep_start_ff) >= cfg.sweep_interval;

   always_comb begin
      total_minute_in = total_minute_ff;
      current_total_in = current_total_ff;
      previous_total_in = previous_total_ff;
      sweep_start_in = sweep_start_ff;
      if (q_push) begin
         if (total_minute_ff == now_n) begin
            if (current_total_ff != TOTAL_MAX) begin
               current_total_in = current_total_ff + 24'd1;
            end
         end else begin
            previous_total_in = current_total_ff;
            current_total_in = 24'd1;
            total_minute_in = now_n;
         end
         if (sweep_due) begin
            sweep_start_in = now_n;
         end
      end
   end

   always_comb begin
      q_job.address = source_address;
      q_job.minute = now_n;
      q_job.sweep = sweep_due;
      q_job.prev_total = previous_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_minute_ff <= 6'd0;
         current_total_ff <= 24'd0;
         previous_total_ff <= 24'd0;
         sweep_start_ff <= 6'd0;
      end else begin
         total_minute_ff <= total_minute_in;
         current_total_ff <= current_total_in;
         previous_total_ff <= previous_total_in;
         sweep_start_ff <= sweep_start_in;
      end
   end

endmodule

FILE: src/prl_queue.sv
// short job queue between front end and table engine
// depends on prl_pkg
module prl_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  prl_pkg::job_type push_job,
   output logic full,
   input  logic pop,
   output prl_pkg::job_type pop_job,
   output logic empty
);
   import prl_pkg::*;

   job_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0] count_ff, count_in;

   assign full = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign pop_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: src/prl_back.sv
// table engine: one pass over the slot memory sweeps and looks up, then updates
// depends on prl_pkg
module prl_back (
   input  logic clock,
   input  logic reset,
   input  prl_pkg::cfg_type cfg,
   input  logic q_empty,
   input  prl_pkg::job_type q_job,
   output logic q_pop,
   input  logic res_pop,
   output logic res_valid,
   output prl_pkg::result_type res
);
   import prl_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   slot_type slot_mem [TABLE_ENTRIES];
   slot_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic mem_we;
   logic [IDX_W-1:0] mem_wa;
   slot_type mem_wd;

   logic [1:0] state_ff, state_in;
   job_type job_ff, job_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0] tracked_ff, tracked_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic issue_ff, issue_in;
   logic chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic found_ff, found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [5:0] hit_minute_ff, hit_minute_in;
   logic [15:0] hit_count_ff, hit_count_in;
   logic free_ff, free_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic res_vld_ff, res_vld_in;
   result_type res_ff, res_in;

   logic entry_v, entry_evict, entry_live;
   logic [15:0] new_count;
   logic [CNT_W-1:0] tracked_out;
   logic fin_allowed, fin_full, res_room;

   assign res_valid = res_vld_ff;
   assign res = res_ff;
   assign res_room = ~res_vld_ff | res_pop;
   assign q_pop = (state_ff == ST_IDLE) & ~q_empty;
   assign rd_addr = rd_ptr_ff;

   assign entry_v = valid_ff[chk_idx_ff];
   assign entry_evict = entry_v & job_ff.sweep &
                        (minute_gap(job_ff.minute, rd_data_ff.minute) >= cfg.idle_limit);
   assign entry_live = entry_v & ~entry_evict;

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      valid_in = valid_ff;
      tracked_in = tracked_ff;
      rd_ptr_in = rd_ptr_ff;
      issue_in = issue_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = rd_ptr_ff;
      found_in = found_ff;
      hit_idx_in = hit_idx_ff;
      hit_minute_in = hit_minute_ff;
      hit_count_in = hit_count_ff;
      free_in = free_ff;
      free_idx_in = free_idx_ff;
      res_vld_in = res_vld_ff & ~res_pop;
      res_in = res_ff;
      mem_we = 1'b0;
      mem_wa = hit_idx_ff;
      mem_wd = '0;
      new_count = 16'd1;
      tracked_out = tracked_ff;
      fin_allowed = 1'b1;
      fin_full = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (~q_empty) begin
               job_in = q_job;
               rd_ptr_in = '0;
               issue_in = 1'b1;
               found_in = 1'b0;
               free_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               chk_vld_in = 1'b1;
               rd_ptr_in = rd_ptr_ff + IDX_W'(1);
               if (rd_ptr_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
                  issue_in = 1'b0;
               end
            end
            if (chk_vld_ff) begin
               if (entry_evict) begin
                  valid_in[chk_idx_ff] = 1'b0;
                  tracked_in = tracked_ff - CNT_W'(1);
               end
               if (entry_live && rd_data_ff.address == job_ff.address && !found_ff) begin
                  found_in = 1'b1;
                  hit_idx_in = chk_idx_ff;
                  hit_minute_in = rd_data_ff.minute;
                  hit_count_in = rd_data_ff.count;
               end
               if (!entry_live && !free_ff) begin
                  free_in = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (chk_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (hit_minute_ff != job_ff.minute) begin
               new_count = 16'd1;
            end else if (hit_count_ff != COUNT_MAX) begin
               new_count = hit_count_ff + 16'd1;
            end else begin
               new_count = hit_count_ff;
            end
            if (cfg.max_per_minute != 16'd0) begin
               if (found_ff) begin
                  mem_wa = hit_idx_ff;
                  mem_wd = '{address: job_ff.address, minute: job_ff.minute,
                             count: new_count};
                  fin_allowed = new_count < cfg.max_per_minute;
               end else if (free_ff) begin
                  mem_wa = free_idx_ff;
                  mem_wd = '{address: job_ff.address, minute: job_ff.minute,
                             count: 16'd1};
                  tracked_out = tracked_ff + CNT_W'(1);
               end else begin
                  fin_full = 1'b1;
               end
            end
            if (res_room) begin
               mem_we = (cfg.max_per_minute != 16'd0) & (found_ff | free_ff);
               if (cfg.max_per_minute != 16'd0 && !found_ff && free_ff) begin
                  valid_in[free_idx_ff] = 1'b1;
               end
               tracked_in = tracked_out;
               res_vld_in = 1'b1;
               res_in.allowed = fin_allowed;
               res_in.table_full = fin_full;
               res_in.tracked_sources = 7'(tracked_out);
               res_in.previous_minute_total = job_ff.prev_total;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rd_ptr_ff <= rd_ptr_in;
      chk_idx_ff <= chk_idx_in;
      hit_idx_ff <= hit_idx_in;
      hit_minute_ff <= hit_minute_in;
      hit_count_ff <= hit_count_in;
      free_idx_ff <= free_idx_in;
      res_ff <= res_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         tracked_ff <= '0;
         issue_ff <= 1'b0;
         chk_vld_ff <= 1'b0;
         found_ff <= 1'b0;
         free_ff <= 1'b0;
         res_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         tracked_ff <= tracked_in;
         issue_ff <= issue_in;
         chk_vld_ff <= chk_vld_in;
         found_ff <= found_in;
         free_ff <= free_in;
         res_vld_ff <= res_vld_in;
      end
   end

endmodule

FILE: src/per_source_connection_rate_limiter.sv
// Per-source connection rate limiter. Each request takes one pass over the
// 64-slot table through the slot memory's single read port (sweep and lookup share
// the pass), so one item occupies the table engine for the whole pass; the front
// end and a two-deep queue take new requests meanwhile, and one result register
// holds the answer until popped.
// Depends on prl_pkg, prl_csr, prl_front, prl_queue and prl_back.
module per_source_connection_rate_limiter (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  logic [31:0] req_source_address,
   input  logic [5:0] req_now_minute,
   output logic empty,
   input  logic pop,
   output logic rsp_allowed,
   output logic rsp_table_full,
   output logic [6:0] rsp_tracked_sources,
   output logic [23:0] rsp_previous_minute_total,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [3:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import prl_pkg::*;

   cfg_type cfg;
   job_type push_job, pop_job;
   result_type res;
   logic q_push, q_full, q_pop, q_empty, res_valid;

   prl_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready), .cfg(cfg)
   );

   prl_front u_front (
      .clock(clock), .reset(reset), .push(push),
      .source_address(req_source_address), .now_minute(req_now_minute),
      .q_full(q_full), .cfg(cfg), .q_push(q_push), .q_job(push_job)
   );

   prl_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_job(push_job),
      .full(q_full), .pop(q_pop), .pop_job(pop_job), .empty(q_empty)
   );

   prl_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg), .q_empty(q_empty),
      .q_job(pop_job), .q_pop(q_pop), .res_pop(pop), .res_valid(res_valid),
      .res(res)
   );

   assign full = q_full;
   assign empty = ~res_valid;
   assign rsp_allowed = res.allowed;
   assign rsp_table_full = res.table_full;
   assign rsp_tracked_sources = res.tracked_sources;
   assign rsp_previous_minute_total = res.previous_minute_total;

   a_full_allows: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_table_full |-> rsp_allowed)
      else $error("table full result refused");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_table_full |-> rsp_tracked_sources == 7'(TABLE_ENTRIES))
      else $error("table full with free slots");

   a_disabled: assert property (@(posedge clock) disable iff (reset)
      !empty && cfg.max_per_minute == 16'd0 |-> rsp_allowed && !rsp_table_full)
      else $error("limit disabled but request refused");

endmodule

FILE: sim/tb.sv
// self-checking bench for per_source_connection_rate_limiter: queue-style request and
// response channels with random bursts and stalls, apb register writes between phases
// depends on prl_pkg and the rate limiter rtl
`timescale 1ns / 1ps

module tb;
   import prl_pkg::*;

   typedef struct {
      logic [31:0] address;
      logic [5:0] minute;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic [31:0] req_source_address = '0;
   logic [5:0] req_now_minute = '0;
   logic empty;
   logic pop = 1'b0;
   logic rsp_allowed;
   logic rsp_table_full;
   logic [6:0] rsp_tracked_sources;
   logic [23:0] rsp_previous_minute_total;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   per_source_connection_rate_limiter dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_source_address(req_source_address), .req_now_minute(req_now_minute),
      .empty(empty), .pop(pop), .rsp_allowed(rsp_allowed),
      .rsp_table_full(rsp_table_full), .rsp_tracked_sources(rsp_tracked_sources),
      .rsp_previous_minute_total(rsp_previous_minute_total),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   localparam int QUIET_CYCLES = 150;
   localparam int WATCHDOG_LIMIT = 4000;

   // limiter state as the bench sees it
   logic [15:0] lim_max;
   logic [5:0] lim_sweep;
   logic [5:0] lim_idle;
   logic src_valid [TABLE_ENTRIES];
   logic [31:0] src_address [TABLE_ENTRIES];
   logic [5:0] src_minute [TABLE_ENTRIES];
   logic [15:0] src_count [TABLE_ENTRIES];
   logic [5:0] tot_minute;
   logic [23:0] tot_current;
   logic [23:0] tot_previous;
   logic [5:0] last_sweep;

   request_type pending_requests[$];
   result_type expected_results[$];
   int errors = 0;
   int accepted_requests = 0;
   int checked_results = 0;
   int refused_seen = 0;
   int full_seen = 0;
   int watchdog = 0;

   function automatic logic [5:0] wrap_gap(input logic [5:0] later, input logic [5:0] earlier);
      return (later >= earlier) ? later - earlier : later + 6'd60 - earlier;
   endfunction

   function automatic result_type rate_predict(input logic [31:0] addr, input logic [5:0] m);
      result_type r;
      logic [5:0] now;
      int hit;
      int cnt;
      now = (m >= 6'd60) ? m - 6'd60 : m;
      r.allowed = 1'b1;
      r.table_full = 1'b0;
      if (tot_minute == now) begin
         if (tot_current != 24'hFFFFFF) tot_current++;
      end else begin
         tot_previous = tot_current;
         tot_current = 24'd1;
         tot_minute = now;
      end
      if (wrap_gap(now, last_sweep) >= lim_sweep) begin
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if (src_valid[i] && wrap_gap(now, src_minute[i]) >= lim_idle) src_valid[i] = 1'b0;
         last_sweep = now;
      end
      if (lim_max != 0) begin
         hit = -1;
         for (int i = 0; i < TABLE_ENTRIES; i++)
            if (hit < 0 && src_valid[i] && src_address[i] == addr) hit = i;
         if (hit >= 0) begin
            if (src_minute[hit] != now) begin
               src_minute[hit] = now;
               src_count[hit] = 16'd1;
            end else if (src_count[hit] != 16'hFFFF) begin
               src_count[hit]++;
            end
            r.allowed = (src_count[hit] >= lim_max) ? 1'b0 : 1'b1;
         end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (hit < 0 && !src_valid[i]) begin
                  hit = i;
                  src_valid[i] = 1'b1;
                  src_address[i] = addr;
                  src_minute[i] = now;
                  src_count[i] = 16'd1;
               end
            if (hit < 0) r.table_full = 1'b1;
         end
      end
      cnt = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) if (src_valid[i]) cnt++;
      r.tracked_sources = cnt[6:0];
      r.previous_minute_total = tot_previous;
      return r;
   endfunction

   // driver: bursts of random length, random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            expected_results.insert(expected_results.size(),
                                    rate_predict(req_source_address, req_now_minute));
            accepted_requests++;
         end
         if (!(push && full)) begin
            if (gap_left > 0) begin
               gap_left--;
               push <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               request_type q;
               q = pending_requests.pop_front();
               req_source_address <= q.address;
               req_now_minute <= q.minute;
               push <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
               end
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   // monitor: pop stalls come in random modes, each held for a random stretch set by mode_left
   int pop_mode = 0;
   int mode_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected item allowed=%0b full=%0b tracked=%0d prev=%0d",
                        $time, rsp_allowed, rsp_table_full, rsp_tracked_sources,
                        rsp_previous_minute_total);
               errors++;
            end else begin
               result_type e;
               e = expected_results.pop_front();
               checked_results++;
               if (!e.allowed) refused_seen++;
               if (e.table_full) full_seen++;
               if (rsp_allowed !== e.allowed) begin
                  $display("%0t: allowed expected %0b actual %0b", $time, e.allowed, rsp_allowed);
                  errors++;
               end
               if (rsp_table_full !== e.table_full) begin
                  $display("%0t: table_full expected %0b actual %0b", $time, e.table_full,
                           rsp_table_full);
                  errors++;
               end
               if (rsp_tracked_sources !== e.tracked_sources) begin
                  $display("%0t: tracked_sources expected %0d actual %0d", $time,
                           e.tracked_sources, rsp_tracked_sources);
                  errors++;
               end
               if (rsp_previous_minute_total !== e.previous_minute_total) begin
                  $display("%0t: previous_minute_total expected %0d actual %0d", $time,
                           e.previous_minute_total, rsp_previous_minute_total);
                  errors++;
               end
            end
         end
         if (mode_left == 0) begin
            pop_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 400);
         end else begin
            mode_left--;
         end
         case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 1) == 1);
            default: pop <= ($urandom_range(0, 99) < 3);
         endcase
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || psel) begin
         watchdog <= 0;
      end else if (!reset) begin
         watchdog <= watchdog + 1;
         if (watchdog >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d items outstanding", $time,
                     expected_results.size());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic reg_write(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_MAX_PER_MINUTE: lim_max = value[15:0];
         REG_SWEEP_INTERVAL: lim_sweep = value[5:0];
         REG_IDLE_LIMIT: lim_idle = value[5:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (pending_requests.size() != 0 || push || expected_results.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] mx, input logic [5:0] sw, input logic [5:0] idl);
      wait_idle();
      reg_write(REG_MAX_PER_MINUTE, {16'd0, mx});
      reg_write(REG_SWEEP_INTERVAL, {26'd0, sw});
      reg_write(REG_IDLE_LIMIT, {26'd0, idl});
   endtask

   task automatic add_request(input logic [31:0] a, input logic [5:0] m);
      request_type q;
      q.address = a;
      q.minute = m;
      pending_requests.insert(pending_requests.size(), q);
   endtask

   // mostly a small pool of sources with a slowly moving clock, some noise
   task automatic add_random(input int n, input int pool_size, input int step_odds);
      logic [31:0] pool[$];
      logic [5:0] m;
      m = 6'($urandom_range(0, 59));
      for (int i = 0; i < pool_size; i++) pool.insert(pool.size(), $urandom);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 3) begin
            m = 6'($urandom_range(0, 63));
         end else if ($urandom_range(1, step_odds) == 1) begin
            m = (m >= 6'd60) ? m - 6'd60 : m;
            m = 6'((m + $urandom_range(1, 3)) % 60);
         end
         if ($urandom_range(0, 9) == 0) add_request($urandom, m);
         else add_request(pool[$urandom_range(0, pool_size - 1)], m);
      end
   endtask

   initial begin
      lim_max = RST_MAX_PER_MINUTE;
      lim_sweep = RST_SWEEP_INTERVAL;
      lim_idle = RST_IDLE_LIMIT;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         src_valid[i] = 1'b0;
         src_address[i] = '0;
         src_minute[i] = '0;
         src_count[i] = '0;
      end
      tot_minute = '0;
      tot_current = '0;
      tot_previous = '0;
      last_sweep = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // limit disabled after reset, field extremes and out-of-range minutes
      add_request(32'h0000_0000, 6'd0);
      add_request(32'hFFFF_FFFF, 6'd0);
      add_request(32'hAAAA_5555, 6'd59);
      add_request(32'h5555_AAAA, 6'd60);
      add_request(32'h0000_0001, 6'd63);

      // tight limit: repeats get refused, new minute restarts the count
      configure(16'd2, 6'd1, 6'd1);
      add_request(32'hC0A8_0001, 6'd5);
      add_request(32'hC0A8_0001, 6'd5);
      add_request(32'hC0A8_0001, 6'd5);
      add_request(32'hFFFF_FFFF, 6'd5);
      add_request(32'hC0A8_0001, 6'd6);
      add_request(32'hC0A8_0001, 6'd63);
      add_request(32'h0000_0000, 6'd3);
      add_request(32'hC0A8_0001, 6'd8);

      // sweep and idle of zero, limit of one
      configure(16'd1, 6'd0, 6'd0);
      add_request(32'h0A00_0001, 6'd10);
      add_request(32'h0A00_0001, 6'd10);
      add_request(32'h0A00_0002, 6'd11);
      add_random(180, 12, 6);

      // largest limit, sweeps and idle eviction never happen
      configure(16'hFFFF, 6'd63, 6'd63);
      add_random(180, 30, 8);

      // overflow the table with one fixed minute
      configure(16'd3, 6'd59, 6'd59);
      for (int i = 0; i < 80; i++) add_request($urandom, 6'd20);
      add_random(110, 90, 30);

      configure(16'd2, 6'd10, 6'd3);
      add_random(200, 20, 4);

      configure(16'd5, 6'd1, 6'd59);
      add_random(180, 50, 10);

      configure(16'd3, 6'd5, 6'd2);
      add_random(200, 25, 5);

      wait_idle();
      $display("%0d requests sent, %0d results checked, %0d refused, %0d table-full",
               accepted_requests, checked_results, refused_seen, full_seen);
      $display("register settings covered limit off, 1, 2, 3, 5, max; sweep/idle 0 to 63");
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
